FILE: hdl/fgcc_pkg.sv
// ----------------------------------------------------------------------------
// fgcc_pkg - shared types and constants of the footprint collision checker
// grid and table sizes, command and configuration types, cordic angle table
// ----------------------------------------------------------------------------
package fgcc_pkg;

  // grid and footprint table geometry
  localparam int CELLS_X    = 256;
  localparam int CELLS_Y    = 256;
  localparam int MAX_POINTS = 64;
  localparam int TAB_DEPTH  = 64;
  localparam int TAB_AW     = 6;
  localparam int GRID_AW    = 16;
  localparam int GRID_DEPTH = 1 << GRID_AW;
  localparam int PT_LIM     = (MAX_POINTS < TAB_DEPTH) ? MAX_POINTS : TAB_DEPTH;
  localparam int CNT_W      = 7;
  localparam int XI_W       = $clog2(CELLS_X);
  localparam int YI_W       = $clog2(CELLS_Y);

  // datapath widths
  localparam int POS_W  = 28;   // map positions and cell offsets, signed
  localparam int CS_W   = 20;   // cordic x/y and sin/cos in q16, signed
  localparam int ZW     = 18;   // cordic residual angle, signed
  localparam int ACC_W  = 46;   // product sums before rounding
  localparam int CS_SZ  = 16;   // cell size width
  localparam int DIV_CW = $clog2(POS_W);

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_GAIN  = 39797;

  localparam int IN_TDATA_W = 128;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  // action codes on the input tuser
  localparam logic [1:0] ACT_CELL  = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // cell statuses that count as blocked
  localparam logic [2:0] ST_BLOCK_LO = 3'd0;
  localparam logic [2:0] ST_BLOCK_HI = 3'd7;

  // register indexes
  localparam logic [2:0] REG_MAX_X      = 3'd0;
  localparam logic [2:0] REG_MAX_Y      = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
  localparam logic [2:0] REG_OFFSET_X   = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd4;
  localparam logic [2:0] REG_OFFSET_HDG = 3'd5;
  localparam logic [2:0] REG_FP_POINTS  = 3'd6;
  localparam logic [2:0] REG_UNUSED     = 3'd7;

  typedef enum logic [1:0] {
    CMD_CELL  = 2'd0,
    CMD_POINT = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [15:0]        cell_address;
    logic [2:0]         cell_status;
    logic [5:0]         point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic [15:0]        pose_heading;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] max_x;
    logic signed [23:0] max_y;
    logic [15:0]        cell_size;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic [15:0]        offset_heading;
    logic [6:0]         footprint_points;
  } cfg_t;

  // arctangent of 2^-k in 1/65536 turn
  function automatic logic [13:0] arc_step(input logic [3:0] k);
    logic [13:0] a;
    unique case (k)
      4'd0:    a = 14'd8192;
      4'd1:    a = 14'd4836;
      4'd2:    a = 14'd2555;
      4'd3:    a = 14'd1297;
      4'd4:    a = 14'd651;
      4'd5:    a = 14'd326;
      4'd6:    a = 14'd163;
      4'd7:    a = 14'd81;
      4'd8:    a = 14'd41;
      4'd9:    a = 14'd20;
      4'd10:   a = 14'd10;
      4'd11:   a = 14'd5;
      4'd12:   a = 14'd3;
      4'd13:   a = 14'd1;
      4'd14:   a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/footprint_grid_collision_check.sv
// ----------------------------------------------------------------------------
// footprint_grid_collision_check - vehicle footprint vs occupancy grid
// grid and footprint writes plus pose queries, one collision beat per query
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_      | in  | tvalid / tready    | tuser action, tdata cell/point/pose
//  out_     | out | tvalid / tready    | tdata[0] collision
//  cfg_     | in  | psel/penable/pready| 7 registers at 4*i
//
//  grid and point writes are done in the back end as they leave the queue
//  a query runs a 28-step shift-subtract divider per point scanned and two
//  16-step cordic passes before its result beat
//  the input side keeps accepting into a two-entry queue while a query runs
//  one result beat waits in the output register, the back end stalls behind it
//  rst_n clears control state only, grid and table contents stay as written
// ----------------------------------------------------------------------------
module footprint_grid_collision_check (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cell_address[15:0] cell_status[18:16] point_index[24:19] point_x[40:25]
  // point_y[56:41] pose_x[80:57] pose_y[104:81] pose_heading[120:105]
  input  logic [fgcc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [1:0]                          in_tuser,   // action[1:0]
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // collision[0]
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [4:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import fgcc_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  logic res_valid, res_collision, res_ready, res_fire;
  logic out_valid_r, out_coll_r;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_x            <= '0;
      cfg_r.max_y            <= '0;
      cfg_r.cell_size        <= 16'd1024;
      cfg_r.offset_x         <= '0;
      cfg_r.offset_y         <= '0;
      cfg_r.offset_heading   <= '0;
      cfg_r.footprint_points <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_X:      cfg_r.max_x            <= cfg_pwdata[23:0];
        REG_MAX_Y:      cfg_r.max_y            <= cfg_pwdata[23:0];
        REG_CELL_SIZE:  cfg_r.cell_size        <= cfg_pwdata[15:0];
        REG_OFFSET_X:   cfg_r.offset_x         <= cfg_pwdata[23:0];
        REG_OFFSET_Y:   cfg_r.offset_y         <= cfg_pwdata[23:0];
        REG_OFFSET_HDG: cfg_r.offset_heading   <= cfg_pwdata[15:0];
        REG_FP_POINTS:  cfg_r.footprint_points <= cfg_pwdata[6:0];
        REG_UNUSED:     ;
        default:        ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_MAX_X:      cfg_prdata = 32'(unsigned'(cfg_r.max_x));
      REG_MAX_Y:      cfg_prdata = 32'(unsigned'(cfg_r.max_y));
      REG_CELL_SIZE:  cfg_prdata = 32'(cfg_r.cell_size);
      REG_OFFSET_X:   cfg_prdata = 32'(unsigned'(cfg_r.offset_x));
      REG_OFFSET_Y:   cfg_prdata = 32'(unsigned'(cfg_r.offset_y));
      REG_OFFSET_HDG: cfg_prdata = 32'(cfg_r.offset_heading);
      REG_FP_POINTS:  cfg_prdata = 32'(cfg_r.footprint_points);
      default:        cfg_prdata = '0;
    endcase
  end

  // front end: decode and queue
  fgcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // back end: memories and query sequencer
  fgcc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .res_valid     (res_valid),
    .res_collision (res_collision),
    .res_ready     (res_ready)
  );

  // output register, refills in the cycle it drains
  assign res_ready = !out_valid_r || out_tready;
  assign res_fire  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_coll_r <= res_collision;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_coll_r};

  // a finished result holds in the back end until the output slot frees
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && (res_collision == $past(res_collision)))
    else $error("back end result changed while stalled");

  // a drained output beat is not repeated without a new result
  a_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !res_fire |=> !out_tvalid)
    else $error("output beat repeated");

endmodule

FILE: hdl/fgcc_front.sv
// ----------------------------------------------------------------------------
// fgcc_front - input beat decode and command queue
// splits the input beat into a command, drops unused actions, buffers two
// ----------------------------------------------------------------------------
module fgcc_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [fgcc_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic [1:0]                            in_tuser,
  output fgcc_pkg::cmd_t                        cmd,
  output logic                                  cmd_valid,
  input  logic                                  cmd_pop
);
  import fgcc_pkg::*;

  cmd_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;
  cmd_t            dec;
  logic            keep, push;

  always_comb begin
    dec.cell_address = in_tdata[15:0];
    dec.cell_status  = in_tdata[18:16];
    dec.point_index  = in_tdata[24:19];
    dec.point_x      = in_tdata[40:25];
    dec.point_y      = in_tdata[56:41];
    dec.pose_x       = in_tdata[80:57];
    dec.pose_y       = in_tdata[104:81];
    dec.pose_heading = in_tdata[120:105];
    keep             = 1'b1;
    unique case (in_tuser)
      ACT_CELL:  dec.kind = CMD_CELL;
      ACT_POINT: dec.kind = CMD_POINT;
      ACT_QUERY: dec.kind = CMD_QUERY;
      default: begin
        dec.kind = CMD_CELL;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_tready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (cmd_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !cmd_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && cmd_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/fgcc_back.sv
// ----------------------------------------------------------------------------
// fgcc_back - command execution
// grid and footprint memories, shared cordic, multiplier and divider sequencer
// ----------------------------------------------------------------------------
module fgcc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  fgcc_pkg::cfg_t cfg,
  input  fgcc_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           res_valid,
  output logic           res_collision,
  input  logic           res_ready
);
  import fgcc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CORD  = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_ADD   = 11'b00000001000,
    S_PREAD = 11'b00000010000,
    S_DIFF  = 11'b00000100000,
    S_DSET  = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_GRID  = 11'b00100000000,
    S_CHK   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [2:0]         grid_mem [GRID_DEPTH];
  logic signed [15:0] tabx_mem [TAB_DEPTH];
  logic signed [15:0] taby_mem [TAB_DEPTH];
  logic [2:0]         grid_q;
  logic signed [15:0] tabx_q, taby_q;

  // datapath registers
  logic                     phase_r;          // 0 pose, 1 footprint points
  logic [3:0]               k_r;
  logic signed [CS_W-1:0]   cx_r, cy_r, c_r, s_r;
  logic signed [ZW-1:0]     cz_r;
  logic                     neg_r;
  logic signed [23:0]       px_r, py_r;
  logic [15:0]              ph_r;
  logic [2:0]               mstep_r;
  logic signed [ACC_W-1:0]  prod_r, accx_r, accy_r;
  logic signed [POS_W-1:0]  mx_r, my_r, x_r, y_r, dx_r, dy_r;
  logic                     dposx_r, dposy_r;
  logic [CS_SZ:0]           remx_r, remy_r;
  logic [POS_W-1:0]         qx_r, qy_r;
  logic [DIV_CW-1:0]        dk_r;
  logic [CNT_W-1:0]         i_r, n_r;
  logic                     hitv_r, coll_r;

  // cordic start
  logic [15:0]            ang;
  logic signed [ZW-1:0]   z0;
  logic                   neg0;
  logic signed [ZW-1:0]   zs;

  always_comb begin
    ang  = (state_r == S_IDLE) ? cfg.offset_heading : ph_r + cfg.offset_heading;
    zs   = ZW'(signed'(ang));
    neg0 = 1'b0;
    z0   = zs;
    if (zs > ZW'(16384)) begin
      z0   = zs - ZW'(32768);
      neg0 = 1'b1;
    end else if (zs < -ZW'(16384)) begin
      z0   = zs + ZW'(32768);
      neg0 = 1'b1;
    end
  end

  // one cordic micro-rotation
  logic signed [CS_W-1:0] nx, ny, xsh, ysh;
  logic signed [ZW-1:0]   nz, at;

  always_comb begin
    xsh = cx_r >>> k_r;
    ysh = cy_r >>> k_r;
    at  = ZW'(signed'({1'b0, arc_step(k_r)}));
    if (cz_r >= 0) begin
      nx = cx_r - ysh;
      ny = cy_r + xsh;
      nz = cz_r - at;
    end else begin
      nx = cx_r + ysh;
      ny = cy_r - xsh;
      nz = cz_r + at;
    end
  end

  // shared multiplier
  logic signed [23:0]      a0, a1, ma;
  logic signed [CS_W-1:0]  mb;
  logic signed [ACC_W-1:0] prod_w;

  always_comb begin
    a0 = phase_r ? 24'(tabx_q) : px_r;
    a1 = phase_r ? 24'(taby_q) : py_r;
    unique case (mstep_r[1:0])
      2'd0: begin ma = a0; mb = c_r; end
      2'd1: begin ma = a1; mb = s_r; end
      2'd2: begin ma = a0; mb = s_r; end
      default: begin ma = a1; mb = c_r; end
    endcase
  end

  assign prod_w = ma * mb;

  // rounding to the nearest, ties up
  logic signed [ACC_W-1:0] rxa, rya;
  logic signed [POS_W-1:0] rx, ry;

  assign rxa = accx_r + ACC_W'(32768);
  assign rya = accy_r + ACC_W'(32768);
  assign rx  = rxa[16 +: POS_W];
  assign ry  = rya[16 +: POS_W];

  // divider step, both axes together
  logic [CS_SZ-1:0] qsz;
  logic [CS_SZ:0]   rshx, rshy;
  logic             gex, gey;

  assign qsz  = (cfg.cell_size == '0) ? CS_SZ'(1) : cfg.cell_size;
  assign rshx = {remx_r[CS_SZ-1:0], qx_r[POS_W-1]};
  assign rshy = {remy_r[CS_SZ-1:0], qy_r[POS_W-1]};
  assign gex  = (rshx >= {1'b0, qsz});
  assign gey  = (rshy >= {1'b0, qsz});

  // cell index and address
  logic                 vx, vy;
  logic [XI_W-1:0]      x0;
  logic [YI_W-1:0]      y0;
  logic [23:0]          gsum;
  logic [GRID_AW-1:0]   gaddr;

  always_comb begin
    vx    = dposx_r ? (qx_r < POS_W'(CELLS_X)) : (qx_r == '0);
    vy    = dposy_r ? (qy_r < POS_W'(CELLS_Y)) : (qy_r == '0);
    x0    = dposx_r ? qx_r[XI_W-1:0] : '0;
    y0    = dposy_r ? qy_r[YI_W-1:0] : '0;
    gsum  = 24'(x0) * 24'(CELLS_Y) + 24'(y0);
    gaddr = gsum[GRID_AW-1:0];
  end

  logic [CNT_W-1:0] npts;
  assign npts = (cfg.footprint_points > CNT_W'(PT_LIM)) ? CNT_W'(PT_LIM) :
                cfg.footprint_points;

  logic blocked;
  assign blocked = hitv_r && (grid_q == ST_BLOCK_LO || grid_q == ST_BLOCK_HI);

  assign cmd_pop       = (state_r == S_IDLE) && cmd_valid;
  assign res_valid     = (state_r == S_DONE);
  assign res_collision = coll_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd_valid && cmd.kind == CMD_QUERY) state_nxt = S_CORD;
      S_CORD: begin
        if (k_r == 4'(CORDIC_STEPS-1)) begin
          if (!phase_r)         state_nxt = S_MUL;
          else if (n_r == '0)   state_nxt = S_DONE;
          else                  state_nxt = S_PREAD;
        end
      end
      S_MUL:   if (mstep_r == 3'd4) state_nxt = S_ADD;
      S_ADD:   state_nxt = phase_r ? S_DIFF : S_CORD;
      S_PREAD: state_nxt = S_MUL;
      S_DIFF:  state_nxt = S_DSET;
      S_DSET:  state_nxt = S_DIV;
      S_DIV:   if (dk_r == DIV_CW'(POS_W-1)) state_nxt = S_GRID;
      S_GRID:  state_nxt = S_CHK;
      S_CHK:   state_nxt = (blocked || i_r + 1'b1 == n_r) ? S_DONE : S_PREAD;
      S_DONE:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_CELL) begin
      grid_mem[cmd.cell_address] <= cmd.cell_status;
    end
    if (state_r == S_GRID) begin
      grid_q <= grid_mem[gaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_POINT) begin
      tabx_mem[cmd.point_index] <= cmd.point_x;
      taby_mem[cmd.point_index] <= cmd.point_y;
    end
    if (state_r == S_PREAD) begin
      tabx_q <= tabx_mem[i_r[TAB_AW-1:0]];
      taby_q <= taby_mem[i_r[TAB_AW-1:0]];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        px_r    <= cmd.pose_x;
        py_r    <= cmd.pose_y;
        ph_r    <= cmd.pose_heading;
        phase_r <= 1'b0;
        k_r     <= '0;
        cx_r    <= CS_W'(CORDIC_GAIN);
        cy_r    <= '0;
        cz_r    <= z0;
        neg_r   <= neg0;
        coll_r  <= 1'b0;
        n_r     <= npts;
      end
      S_CORD: begin
        cx_r    <= nx;
        cy_r    <= ny;
        cz_r    <= nz;
        k_r     <= k_r + 1'b1;
        mstep_r <= '0;
        i_r     <= '0;
        if (k_r == 4'(CORDIC_STEPS-1)) begin
          c_r <= neg_r ? -nx : nx;
          s_r <= neg_r ? -ny : ny;
        end
      end
      S_MUL: begin
        prod_r  <= prod_w;
        mstep_r <= mstep_r + 1'b1;
        unique case (mstep_r)
          3'd1:    accx_r <= prod_r;
          3'd2:    accx_r <= accx_r - prod_r;
          3'd3:    accy_r <= prod_r;
          3'd4:    accy_r <= accy_r + prod_r;
          default: ;
        endcase
      end
      S_ADD: begin
        if (!phase_r) begin
          mx_r    <= rx + POS_W'(cfg.offset_x);
          my_r    <= ry + POS_W'(cfg.offset_y);
          phase_r <= 1'b1;
          k_r     <= '0;
          cx_r    <= CS_W'(CORDIC_GAIN);
          cy_r    <= '0;
          cz_r    <= z0;
          neg_r   <= neg0;
        end else begin
          x_r <= rx + mx_r;
          y_r <= ry + my_r;
        end
      end
      S_PREAD: mstep_r <= '0;
      S_DIFF: begin
        dx_r <= POS_W'(cfg.max_x) - x_r;
        dy_r <= POS_W'(cfg.max_y) - y_r;
      end
      S_DSET: begin
        // ceil for positive, truncation for the rest
        dposx_r <= (dx_r > 0);
        dposy_r <= (dy_r > 0);
        qx_r    <= (dx_r > 0) ? POS_W'(dx_r - 1) : POS_W'(-dx_r);
        qy_r    <= (dy_r > 0) ? POS_W'(dy_r - 1) : POS_W'(-dy_r);
        remx_r  <= '0;
        remy_r  <= '0;
        dk_r    <= '0;
      end
      S_DIV: begin
        remx_r <= gex ? rshx - {1'b0, qsz} : rshx;
        remy_r <= gey ? rshy - {1'b0, qsz} : rshy;
        qx_r   <= {qx_r[POS_W-2:0], gex};
        qy_r   <= {qy_r[POS_W-2:0], gey};
        dk_r   <= dk_r + 1'b1;
      end
      S_GRID:  hitv_r <= vx && vy;
      S_CHK: begin
        coll_r <= blocked;
        i_r    <= i_r + 1'b1;
      end
      S_DONE:  ;
      default: ;
    endcase
  end

endmodule

FILE: bench/footprint_grid_collision_check_tb.sv
// ----------------------------------------------------------------------------
// footprint_grid_collision_check_tb - self-checking bench for the collision checker
// fills the footprint table, writes each grid cell ahead of the first query
// that reads it, then runs directed and random cell, point and query beats
// under several register settings and handshake idling; each collision beat
// is checked against a local predictor
// ----------------------------------------------------------------------------
module footprint_grid_collision_check_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fgcc_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;

  // action code with no meaning, the block drops it
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // cell_address[15:0] cell_status[18:16] point_index[24:19] point_x[40:25]
  // point_y[56:41] pose_x[80:57] pose_y[104:81] pose_heading[120:105]
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;   // action[1:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;  // collision[0]
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  footprint_grid_collision_check i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // register shadow of the block
  longint sh_max_x, sh_max_y, sh_off_x, sh_off_y;
  longint sh_cell_size, sh_off_hdg, sh_fp_points;

  // grid and footprint table shadow
  logic [2:0] grid_shadow [GRID_DEPTH];
  bit         grid_written [GRID_DEPTH];
  longint     fp_x [TAB_DEPTH];
  longint     fp_y [TAB_DEPTH];

  bit     collision_due [$];   // expected collision bits, oldest first
  int     error_count;
  int     snd_idle_pct;
  int     rcv_idle_pct;
  longint cycle_count;

  // arctangent of 2^-k in 1/65536 turn
  const int atan_turn [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                               41, 20, 10, 5, 3, 1, 1, 0};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // q16 cos/sin of a 1/65536-turn angle by a 16-step rotation
  task automatic cordic_q16(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit     flip;
    z = longint'($signed(ang));
    x = 39797;
    y = 0;
    flip = 1'b0;
    if (z > 16384) begin
      z -= 32768;
      flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_turn[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_turn[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // round to nearest, ties toward +inf
  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint div_up(longint d, longint q);
    if (d > 0) return (d + q - 1) / q;
    return -((-d) / q);
  endfunction

  // scan as the block does; stops at a blocked cell or at the first
  // in-range cell that has never been written (gap)
  task automatic predict_collision(input longint px, input longint py,
                                   input logic [15:0] hdg, output bit hit,
                                   output bit gap, output int unsigned gap_addr);
    longint c, s, mx, my, x, y, xi, yi, q, n;
    logic [15:0] sum_hdg;
    int unsigned addr;
    cordic_q16(sh_off_hdg[15:0], c, s);
    mx = round_q16(px * c - py * s) + sh_off_x;
    my = round_q16(px * s + py * c) + sh_off_y;
    sum_hdg = hdg + sh_off_hdg[15:0];
    cordic_q16(sum_hdg, c, s);
    q = (sh_cell_size == 0) ? 1 : sh_cell_size;
    n = (sh_fp_points > PT_LIM) ? PT_LIM : sh_fp_points;
    hit      = 1'b0;
    gap      = 1'b0;
    gap_addr = 0;
    for (int i = 0; i < n && !hit && !gap; i++) begin
      x  = round_q16(fp_x[i] * c - fp_y[i] * s) + mx;
      y  = round_q16(fp_y[i] * c + fp_x[i] * s) + my;
      xi = div_up(sh_max_x - x, q);
      yi = div_up(sh_max_y - y, q);
      if (xi == 0) xi = 1;
      if (yi == 0) yi = 1;
      if (xi >= 1 && xi <= CELLS_X && yi >= 1 && yi <= CELLS_Y) begin
        addr = 32'(((xi - 1) * CELLS_Y + (yi - 1)) % GRID_DEPTH);
        if (!grid_written[addr]) begin
          gap      = 1'b1;
          gap_addr = addr;
        end else if (grid_shadow[addr] == ST_BLOCK_LO ||
                     grid_shadow[addr] == ST_BLOCK_HI) begin
          hit = 1'b1;
        end
      end
    end
  endtask

  // update the shadow for one accepted beat
  task automatic apply_beat(input logic [1:0] act, input logic [127:0] d);
    bit          hit, gap;
    int unsigned gap_addr;
    case (act)
      ACT_CELL: begin
        grid_shadow[d[15:0]]  = d[18:16];
        grid_written[d[15:0]] = 1'b1;
      end
      ACT_POINT: begin
        fp_x[d[24:19]] = longint'($signed(d[40:25]));
        fp_y[d[24:19]] = longint'($signed(d[56:41]));
      end
      ACT_QUERY: begin
        predict_collision(longint'($signed(d[80:57])), longint'($signed(d[104:81])),
                          d[120:105], hit, gap, gap_addr);
        collision_due.insert(collision_due.size(), hit);
      end
      default: ;  // unused action, nothing happens
    endcase
  endtask

  // ------------------------------------------------------------------------
  // beat drivers
  // ------------------------------------------------------------------------

  // random content in every field, callers overwrite what matters
  function automatic logic [127:0] random_beat();
    logic [127:0] d;
    d = {$urandom, $urandom, $urandom, $urandom};
    d[127:121] = '0;
    return d;
  endfunction

  // mostly free cells, about one in twelve blocked
  function automatic logic [2:0] random_status();
    if ($urandom_range(11) == 0) return $urandom_range(1) ? ST_BLOCK_HI : ST_BLOCK_LO;
    return 3'($urandom_range(1, 6));
  endfunction

  // status for a cell first written just before a query reads it
  function automatic logic [2:0] fresh_status();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? ST_BLOCK_HI : ST_BLOCK_LO;
    return 3'($urandom_range(1, 6));
  endfunction

  // send one beat; entered and left at a rising edge
  task automatic send_beat(input logic [1:0] act, input logic [127:0] d);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= d;
    // tready is settled by the falling edge and holds to the next rising one
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    apply_beat(act, d);
  endtask

  task automatic send_cell(input logic [15:0] addr, input logic [2:0] st);
    logic [127:0] d;
    d = random_beat();
    d[15:0]  = addr;
    d[18:16] = st;
    send_beat(ACT_CELL, d);
  endtask

  task automatic send_point(input logic [5:0] idx, input logic [15:0] px, input logic [15:0] py);
    logic [127:0] d;
    d = random_beat();
    d[24:19] = idx;
    d[40:25] = px;
    d[56:41] = py;
    send_beat(ACT_POINT, d);
  endtask

  task automatic send_query(input longint px, input longint py, input logic [15:0] hdg);
    logic [127:0] d;
    bit           hit, gap;
    int unsigned  gap_addr;
    // write every cell the scan would read that holds nothing yet
    gap = 1'b1;
    while (gap) begin
      predict_collision(longint'($signed(px[23:0])), longint'($signed(py[23:0])),
                        hdg, hit, gap, gap_addr);
      if (gap) send_cell(16'(gap_addr), fresh_status());
    end
    d = random_beat();
    d[80:57]   = px[23:0];
    d[104:81]  = py[23:0];
    d[120:105] = hdg;
    send_beat(ACT_QUERY, d);
  endtask

  // stop sending, let every result drain and the back end go quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (collision_due.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input longint val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val[31:0];
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_MAX_X:      sh_max_x     = longint'($signed(val[23:0]));
      REG_MAX_Y:      sh_max_y     = longint'($signed(val[23:0]));
      REG_CELL_SIZE:  sh_cell_size = val[15:0];
      REG_OFFSET_X:   sh_off_x     = longint'($signed(val[23:0]));
      REG_OFFSET_Y:   sh_off_y     = longint'($signed(val[23:0]));
      REG_OFFSET_HDG: sh_off_hdg   = val[15:0];
      REG_FP_POINTS:  sh_fp_points = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input longint mx, input longint my, input longint cs,
                          input longint ox, input longint oy, input longint oh,
                          input longint np);
    drain();
    reg_write(REG_MAX_X, mx);
    reg_write(REG_MAX_Y, my);
    reg_write(REG_CELL_SIZE, cs);
    reg_write(REG_OFFSET_X, ox);
    reg_write(REG_OFFSET_Y, oy);
    reg_write(REG_OFFSET_HDG, oh);
    reg_write(REG_FP_POINTS, np);
  endtask

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // receiver stalls, changed only at the rising edge
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // a beat seen valid and ready at the falling edge is taken at the next rising one
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (collision_due.size() == 0) begin
        report_mismatch($sformatf("collision beat %0b with none expected", out_tdata[0]));
      end else begin
        if (out_tdata[0] !== collision_due[0])
          report_mismatch($sformatf("collision %0b, expected %0b",
                                    out_tdata[0], collision_due[0]));
        void'(collision_due.pop_front());
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("** footprint_grid_collision_check: FAILED **");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // writes every table point; grid cells follow ahead of the queries that read them
  task automatic test_fill();
    snd_idle_pct = 0;
    for (int i = 0; i < TAB_DEPTH; i++)
      send_point(6'(i), 16'($urandom_range(0, 6000) - 3000), 16'($urandom_range(0, 4000) - 2000));
  endtask

  task automatic test_directed();
    snd_idle_pct = 16;
    rcv_idle_pct = 76;
    set_regs(131072, 131072, 1024, 0, 0, 0, 4);
    // block the cell under the origin, then free it
    send_cell(16'(127 * CELLS_Y + 127), ST_BLOCK_HI);
    send_query(0, 0, 16'd0);
    send_cell(16'(127 * CELLS_Y + 127), 3'd3);
    send_point(6'd0, 16'h7fff, 16'h8000);
    send_point(6'd63, 16'h8000, 16'h7fff);
    send_query(0, 0, 16'd16384);
    send_query(0, 0, 16'd32768);
    send_query(0, 0, 16'd49152);
    send_query(0, 0, 16'hffff);
    send_query(0, 0, 16'd8192);
    send_query(8388607, -8388608, 16'd0);
    send_query(-8388608, 8388607, 16'd24576);
    send_query(131072, 131072, 16'd0);           // exactly on the upper edge
    send_query(-131072, -131071, 16'd0);
    send_beat(ACT_SPARE, random_beat());          // unused action, no result
    send_beat(ACT_SPARE, '1 >> 7);
    // no points configured: never a collision
    set_regs(131072, 131072, 1024, 0, 0, 0, 0);
    send_query(0, 0, 16'd100);
    // zero cell size acts as one
    set_regs(0, 0, 0, 0, 0, 0, 3);
    send_query(-100, -100, 16'd0);
    send_query(-5, 0, 16'd40000);
    // count above the table size is limited
    set_regs(131072, 131072, 1024, 0, 0, 0, 127);
    send_query(0, 0, 16'd0);
    send_query(5000, -7000, 16'd1234);
  endtask

  // one random phase under one register setting
  task automatic test_random(input longint mx, input longint my, input longint cs,
                             input longint ox, input longint oy, input longint oh,
                             input longint np, input int beats);
    longint q, cx, cy, px, py;
    int     pick;
    set_regs(mx, my, cs, ox, oy, oh, np);
    q  = (cs == 0) ? 1 : cs;
    cx = mx - 128 * q - ox;
    cy = my - 128 * q - oy;
    for (int k = 0; k < beats; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(4) == 0) begin
          px = longint'($signed(24'($urandom)));
          py = longint'($signed(24'($urandom)));
        end else begin
          px = cx + longint'($urandom_range(0, 300 * q)) - 150 * q;
          py = cy + longint'($urandom_range(0, 300 * q)) - 150 * q;
          if (px > 8388607) px = 8388607;
          if (px < -8388608) px = -8388608;
          if (py > 8388607) py = 8388607;
          if (py < -8388608) py = -8388608;
        end
        send_query(px, py, 16'($urandom));
      end else if (pick < 78) begin
        send_cell(16'($urandom), random_status());
      end else if (pick < 95) begin
        if ($urandom_range(3) == 0) send_point(6'($urandom), 16'($urandom), 16'($urandom));
        else send_point(6'($urandom), 16'($urandom_range(0, 8000) - 4000),
                        16'($urandom_range(0, 6000) - 3000));
      end else begin
        send_beat(ACT_SPARE, random_beat());
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = ACT_CELL;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    error_count  = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    sh_max_x = 0; sh_max_y = 0; sh_off_x = 0; sh_off_y = 0;
    sh_cell_size = 1024; sh_off_hdg = 0; sh_fp_points = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill();
    test_directed();
    // sender idles lightly, receiver heavily
    test_random(131072, 131072, 1024, 0, 0, 0, 6, 180);
    test_random(65536, 200000, 512, 3000, -2000, 12000, 8, 180);
    // the other way round
    snd_idle_pct = 76;
    rcv_idle_pct = 16;
    test_random(8388607, 8388607, 65535, 0, 0, 0, 3, 160);
    test_random(-8388608, -8388608, 0, 0, 0, 0, 2, 160);
    // no idling
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(0, 0, 1024, -8388608, 8388607, 65535, 127, 30);
    test_random(0, 0, 1024, 0, 0, 32768, 16, 160);

    drain();
    if (error_count == 0) begin
      $display("** footprint_grid_collision_check: PASSED **");
    end else begin
      $display("** footprint_grid_collision_check: FAILED **");
    end
    $finish;
  end

endmodule
